FILE: src/cdate_pkg.sv
// ----------------------------------------------------------------------------
// cdate_pkg: shared types and constants for the seconds-to-civil-date core
// Widths, calendar constants in seconds, month-length lookup in seconds and
// the year-tracker control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cdate_pkg;

  // Field widths
  localparam int IN_W     = 38;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  // Internal widths
  localparam int YCNT_W   = 17;   // year counter, covers MAX_YEAR up to 131071

  // Calendar constants, in seconds
  localparam logic [IN_W-1:0]   SECS_PER_MIN     = 38'd60;
  localparam logic [IN_W-1:0]   SECS_PER_HOUR    = 38'd3600;
  localparam logic [IN_W-1:0]   SECS_PER_DAY     = 38'd86400;
  localparam logic [IN_W-1:0]   SECS_28_DAYS     = 38'd2419200;
  localparam logic [IN_W-1:0]   SECS_29_DAYS     = 38'd2505600;
  localparam logic [IN_W-1:0]   SECS_30_DAYS     = 38'd2592000;
  localparam logic [IN_W-1:0]   SECS_31_DAYS     = 38'd2678400;
  localparam logic [IN_W-1:0]   SECS_COMMON_YEAR = 38'd31536000;
  localparam logic [IN_W-1:0]   SECS_LEAP_YEAR   = 38'd31622400;

  // Epoch year and its residues
  localparam logic [YCNT_W-1:0] EPOCH_YEAR   = 17'd1970;
  localparam logic [6:0]        EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400 = 9'd370;

  // Year tracker control and status
  typedef struct packed {
    logic init;   // load the epoch year
    logic inc;    // step to the next year
  } yr_ctl_t;

  typedef struct packed {
    logic [YCNT_W-1:0] year;
    logic              leap;
  } yr_stat_t;

  // Seconds in month m (1..12); February follows the leap flag
  function automatic logic [IN_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [IN_W-1:0] secs;
    case (m)
      4'd2:    secs = leap ? SECS_29_DAYS : SECS_28_DAYS;
      4'd4:    secs = SECS_30_DAYS;
      4'd6:    secs = SECS_30_DAYS;
      4'd9:    secs = SECS_30_DAYS;
      4'd11:   secs = SECS_30_DAYS;
      default: secs = SECS_31_DAYS;
    endcase
    return secs;
  endfunction

endpackage

`default_nettype wire

FILE: src/cdate_sub.sv
// ----------------------------------------------------------------------------
// cdate_sub: shared compare-and-subtract unit
// Gives a >= b and a - b; used for every year, month, day, hour and minute
// walk step.
// ----------------------------------------------------------------------------
`default_nettype none

module cdate_sub (
  input  wire logic [cdate_pkg::IN_W-1:0] a,
  input  wire logic [cdate_pkg::IN_W-1:0] b,
  output logic                            ge,
  output logic [cdate_pkg::IN_W-1:0]      diff
);
  import cdate_pkg::*;

  logic [IN_W:0] sub;

  // one wide subtract, borrow gives the compare
  assign sub  = {1'b0, a} - {1'b0, b};
  assign ge   = ~sub[IN_W];
  assign diff = sub[IN_W-1:0];

endmodule

`default_nettype wire

FILE: src/cdate_year.sv
// ----------------------------------------------------------------------------
// cdate_year: year counter with Gregorian leap tracking
// Keeps the year with running mod-100 and mod-400 counts so the leap test
// needs no divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cdate_year (
  input  wire logic                clk,
  input  wire cdate_pkg::yr_ctl_t  ctl,
  output cdate_pkg::yr_stat_t      stat
);
  import cdate_pkg::*;

  logic [YCNT_W-1:0] year_r, year_nxt;
  logic [6:0]        m100_r, m100_nxt;
  logic [8:0]        m400_r, m400_nxt;

  // next year and wrapped residues
  always_comb begin
    year_nxt = year_r;
    m100_nxt = m100_r;
    m400_nxt = m400_r;
    if (ctl.init) begin
      year_nxt = EPOCH_YEAR;
      m100_nxt = EPOCH_MOD100;
      m400_nxt = EPOCH_MOD400;
    end else if (ctl.inc) begin
      year_nxt = year_r + 1'b1;
      m100_nxt = (m100_r == 7'd99)  ? 7'd0 : m100_r + 1'b1;
      m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    year_r <= year_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
  end

  // divisible by 4 and not 100, or by 400
  assign stat.year = year_r;
  assign stat.leap = ((year_r[1:0] == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);

endmodule

`default_nettype wire

FILE: src/unix_seconds_to_civil_date_core.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_date_core: seconds since 1970-01-01 to civil date
// Input channel (in_valid/in_ready) takes one word: a 38-bit second count.
// Output channel (out_valid/out_ready) gives one word per input: year, month,
// day, hour, minute, second and an out-of-range flag (date fields zero then).
// One compare/subtract unit walks the count down under a small sequencer,
// taking one whole unit off per cycle and stepping once more to see it end:
//   years   from 1970, 365 or 366 days in seconds each
//   months  up to 12; days up to 31
//   hours, then minutes; then the result load
// Counts past MAX_YEAR keep walking whole years to find the time of day.
// in_ready is high only when idle, which follows each load; one word is
// worked at a time. The result sits in an output register, so a new word
// is accepted while a finished one waits; if the receiver stalls with a
// result pending, the next one holds in the load step. Synchronous reset
// returns to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_seconds_to_civil_date_core #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cdate_pkg::IN_W-1:0]    in_total_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cdate_pkg::YEAR_W-1:0]       out_year,
  output logic [cdate_pkg::MONTH_W-1:0]      out_month,
  output logic [cdate_pkg::DAY_W-1:0]        out_day,
  output logic [cdate_pkg::HOUR_W-1:0]       out_hour,
  output logic [cdate_pkg::MIN_W-1:0]        out_minute,
  output logic [cdate_pkg::SEC_W-1:0]        out_second,
  output logic                               out_out_of_range
);
  import cdate_pkg::*;

  localparam logic [YCNT_W-1:0] MaxYear = YCNT_W'(MAX_YEAR);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_YEAR   = 3'd1;
  localparam logic [2:0] S_MONTH  = 3'd2;
  localparam logic [2:0] S_DAY    = 3'd3;
  localparam logic [2:0] S_HOUR   = 3'd4;
  localparam logic [2:0] S_MIN    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [IN_W-1:0]     rem_r, rem_nxt;
  logic [MONTH_W-1:0]  mon_r, mon_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [HOUR_W-1:0]   hr_r, hr_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                load_out;
  logic                oor;

  logic [IN_W-1:0]     op_b, diff;
  logic                ge;

  yr_ctl_t             yctl;
  yr_stat_t            ystat;

  cdate_sub u_sub (
    .a    (rem_r),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  cdate_year u_year (
    .clk  (clk),
    .ctl  (yctl),
    .stat (ystat)
  );

  // unit to take off the remaining count
  always_comb begin
    op_b = '0;
    case (state_r)
      S_YEAR: begin
        op_b = ystat.leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
      end
      S_MONTH: begin
        op_b = month_secs(mon_r, ystat.leap);
      end
      S_DAY: begin
        op_b = SECS_PER_DAY;
      end
      S_HOUR: begin
        op_b = SECS_PER_HOUR;
      end
      S_MIN: begin
        op_b = SECS_PER_MIN;
      end
      default: begin
        op_b = '0;
      end
    endcase
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign oor      = (ystat.year > MaxYear);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    hr_nxt    = hr_r;
    min_nxt   = min_r;
    yctl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rem_nxt   = in_total_seconds;
          yctl.init = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ge) begin
          rem_nxt  = diff;
          yctl.inc = 1'b1;
        end else begin
          mon_nxt   = 4'd1;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (ge) begin
          rem_nxt = diff;
          mon_nxt = mon_r + 1'b1;
        end else begin
          day_nxt   = 5'd1;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        if (ge) begin
          rem_nxt = diff;
          day_nxt = day_r + 1'b1;
        end else begin
          hr_nxt    = '0;
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        if (ge) begin
          rem_nxt = diff;
          hr_nxt  = hr_r + 1'b1;
        end else begin
          min_nxt   = '0;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        // what is left is the second of the minute
        if (ge) begin
          rem_nxt = diff;
          min_nxt = min_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    hr_r   <= hr_nxt;
    min_r  <= min_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_year         <= oor ? '0 : ystat.year[YEAR_W-1:0];
      out_month        <= oor ? '0 : mon_r;
      out_day          <= oor ? '0 : day_r;
      out_hour         <= hr_r;
      out_minute       <= min_r;
      out_second       <= rem_r[SEC_W-1:0];
      out_out_of_range <= oor;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/cdate_checker.sv
// ----------------------------------------------------------------------------
// cdate_checker: port-level checks for the civil date core
// Watches the top-level ports only; bound to every core instance.
// ----------------------------------------------------------------------------
`default_nettype none

module cdate_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [cdate_pkg::YEAR_W-1:0]  out_year,
  input wire logic [cdate_pkg::MONTH_W-1:0] out_month,
  input wire logic [cdate_pkg::DAY_W-1:0]   out_day,
  input wire logic [cdate_pkg::HOUR_W-1:0]  out_hour,
  input wire logic [cdate_pkg::MIN_W-1:0]   out_minute,
  input wire logic [cdate_pkg::SEC_W-1:0]   out_second,
  input wire logic                          out_out_of_range
);
  import cdate_pkg::*;

  // a stalled result word holds its date, second and range flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day) && $stable(out_second) && $stable(out_out_of_range))
    else $error("result word changed while stalled");

  // in_ready drops once a word is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before conversion finished");

  // out of range zeroes the date
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_year == '0 && out_month == '0 && out_day == '0)
    else $error("date fields not zero when out of range");

  // in-range results are legal calendar values
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_month >= 4'd1 && out_month <= 4'd12
      && out_day >= 5'd1 && out_hour <= 5'd23 && out_minute <= 6'd59
      && out_second <= 6'd59 && out_year >= 14'd1970)
    else $error("result field out of calendar range");

endmodule

bind unix_seconds_to_civil_date_core cdate_checker u_cdate_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day          (out_day),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_second       (out_second),
  .out_out_of_range (out_out_of_range)
);

`default_nettype wire
